// File: design/wvsd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the wind vector to speed/direction unit.
// No dependencies; imported by every module of the block.
package wvsd_pkg;

  localparam int TABLE_LEN  = 24;
  localparam int SQRT_STEPS = 17;   // one root bit per stage, bit weights 2^32 .. 2^0
  localparam int XW         = 43;   // CORDIC x/y width, magnitudes shifted up by 24
  localparam int ZW         = 22;   // angle accumulator, 1/16384 degree
  localparam int RW         = 34;   // square root remainder/root width

  // atan(2^-i) in 1/16384 degree, rounded to nearest
  localparam logic [19:0] ATAN_TABLE [TABLE_LEN] = '{
    20'd737280, 20'd435242, 20'd229970, 20'd116736, 20'd58595, 20'd29326,
    20'd14667,  20'd7334,   20'd3667,   20'd1833,   20'd917,   20'd458,
    20'd229,    20'd115,    20'd57,     20'd29,     20'd14,    20'd7,
    20'd4,      20'd2,      20'd1,      20'd0,      20'd0,     20'd0
  };

  // knots to m/s: (m*1852 + 1800) / 3600, divide done as multiply by ceil(2^38/3600)
  localparam logic [10:0] KNOT_MUL   = 11'd1852;
  localparam logic [10:0] KNOT_BIAS  = 11'd1800;
  localparam logic [26:0] KNOT_RECIP = 27'd76354975;
  localparam int          KNOT_SHIFT = 38;

  localparam logic [RW-1:0] SQ_TOP = 34'h1_0000_0000;

  localparam logic signed [ZW-1:0] Z_90 = 22'sd1474560;
  localparam logic [22:0] DIR_90     = 23'd1474560;
  localparam logic [22:0] DIR_270    = 23'd4423680;
  localparam logic [22:0] DIR_ROUND  = 23'd128;
  localparam logic [14:0] DIR_FULL   = 15'd23040;  // 360 degrees in 1/64 degree
  localparam logic [14:0] DIR_CALM   = 15'd17280;  // 270 degrees, zero vector

  typedef struct packed {
    logic [16:0] mag_u;
    logic [16:0] mag_v;
    logic        neg_u;
    logic        neg_v;
    logic [31:0] sum_sq;
  } prep_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic [RW-1:0]        rem;
    logic [RW-1:0]        root;
    logic                 neg_u;
    logic                 neg_v;
    logic                 u_zero;
    logic                 v_zero;
  } core_t;

  typedef struct packed {
    logic [15:0] speed;
    logic [14:0] direction;
  } res_t;

endpackage

// File: design/wvsd_prep.sv
`timescale 1ns / 1ps
// Front end: magnitudes and signs, optional knot scaling, sum of squares.
// Four register stages; depends on wvsd_pkg.
module wvsd_prep (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                knots,
  input  logic                in_valid,
  input  logic [15:0]         in_u,
  input  logic [15:0]         in_v,
  output logic                out_valid,
  output wvsd_pkg::prep_t     out_data
);
  import wvsd_pkg::*;

  logic        v1, v2, v3;
  logic [16:0] au1, av1, au2, av2, mu3, mv3;
  logic        nu1, nv1, nu2, nv2, nu3, nv3;
  logic [25:0] su2, sv2;
  logic [52:0] prod_u, prod_v;
  logic [16:0] mu_next, mv_next;

  // stage 3: exact divide by 3600 through the reciprocal
  assign prod_u  = {27'd0, su2} * {26'd0, KNOT_RECIP};
  assign prod_v  = {27'd0, sv2} * {26'd0, KNOT_RECIP};
  assign mu_next = knots ? {2'b00, prod_u[KNOT_SHIFT+14:KNOT_SHIFT]} : au2;
  assign mv_next = knots ? {2'b00, prod_v[KNOT_SHIFT+14:KNOT_SHIFT]} : av2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      au1 <= in_u[15] ? (17'h10000 - {1'b0, in_u}) : {1'b0, in_u};
      av1 <= in_v[15] ? (17'h10000 - {1'b0, in_v}) : {1'b0, in_v};
      nu1 <= in_u[15];
      nv1 <= in_v[15];

      su2 <= 26'({9'd0, au1} * {15'd0, KNOT_MUL}) + {15'd0, KNOT_BIAS};
      sv2 <= 26'({9'd0, av1} * {15'd0, KNOT_MUL}) + {15'd0, KNOT_BIAS};
      au2 <= au1;
      av2 <= av1;
      nu2 <= nu1;
      nv2 <= nv1;

      mu3 <= mu_next;
      mv3 <= mv_next;
      nu3 <= nu2 & (mu_next != 17'd0);
      nv3 <= nv2 & (mv_next != 17'd0);

      out_data.mag_u  <= mu3;
      out_data.mag_v  <= mv3;
      out_data.neg_u  <= nu3;
      out_data.neg_v  <= nv3;
      out_data.sum_sq <= 32'({17'd0, mu3} * {17'd0, mu3}) + 32'({17'd0, mv3} * {17'd0, mv3});
    end
  end

endmodule

// File: design/wvsd_core.sv
`timescale 1ns / 1ps
// Iteration pipeline: one CORDIC vectoring step and one square root bit per stage.
// Depends on wvsd_pkg.
module wvsd_core #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  wvsd_pkg::prep_t     in_data,
  output logic                out_valid,
  output wvsd_pkg::core_t     out_data
);
  import wvsd_pkg::*;

  localparam int DEPTH = (CORDIC_STEPS > SQRT_STEPS) ? CORDIC_STEPS : SQRT_STEPS;

  core_t init;
  core_t pipe [1:DEPTH];
  core_t nxt  [0:DEPTH-1];
  logic  vld  [1:DEPTH];

  function automatic core_t step(core_t s, int i);
    core_t                r;
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    logic signed [ZW-1:0] da;
    logic [RW-1:0]        sq_bit;
    logic [RW-1:0]        test;
    r = s;
    if (i < CORDIC_STEPS) begin
      dx = s.y >>> i;
      dy = s.x >>> i;
      da = $signed({2'b00, ATAN_TABLE[5'(i)]});
      if (!s.y[XW-1]) begin
        r.x = s.x + dx;
        r.y = s.y - dy;
        r.z = s.z + da;
      end else begin
        r.x = s.x - dx;
        r.y = s.y + dy;
        r.z = s.z - da;
      end
    end
    if (i < SQRT_STEPS) begin
      sq_bit = SQ_TOP >> (2 * i);
      test   = s.root + sq_bit;
      if (s.rem >= test) begin
        r.rem  = s.rem - test;
        r.root = (s.root >> 1) + sq_bit;
      end else begin
        r.root = s.root >> 1;
      end
    end
    return r;
  endfunction

  always_comb begin
    init.x      = $signed({2'b00, in_data.mag_u, 24'd0});
    init.y      = $signed({2'b00, in_data.mag_v, 24'd0});
    init.z      = '0;
    init.rem    = {2'b00, in_data.sum_sq};
    init.root   = '0;
    init.neg_u  = in_data.neg_u;
    init.neg_v  = in_data.neg_v;
    init.u_zero = (in_data.mag_u == 17'd0);
    init.v_zero = (in_data.mag_v == 17'd0);
  end

  always_comb begin
    nxt[0] = step(init, 0);
    for (int i = 1; i < DEPTH; i++) begin
      nxt[i] = step(pipe[i], i);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= DEPTH; i++) begin
        vld[i] <= 1'b0;
      end
    end else if (en) begin
      vld[1] <= in_valid;
      for (int i = 2; i <= DEPTH; i++) begin
        vld[i] <= vld[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < DEPTH; i++) begin
        pipe[i+1] <= nxt[i];
      end
    end
  end

  assign out_valid = vld[DEPTH];
  assign out_data  = pipe[DEPTH];

endmodule

// File: design/wvsd_post.sv
`timescale 1ns / 1ps
// Back end: root rounding, angle clamp, quadrant fold to direction, 1/64 degree rounding.
// Two register stages; depends on wvsd_pkg.
module wvsd_post (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  wvsd_pkg::core_t     in_data,
  output logic                out_valid,
  output wvsd_pkg::res_t      out_data
);
  import wvsd_pkg::*;

  logic        v1;
  logic [20:0] zc;
  logic [22:0] dir_next;
  logic [22:0] dir1;
  logic [15:0] speed1;
  logic        calm1;
  logic [22:0] dir_rnd;
  logic [14:0] dq;

  always_comb begin
    // clamp to [0, 90] degrees; axis vectors bypass the CORDIC angle
    if (in_data.v_zero) begin
      zc = '0;
    end else if (in_data.u_zero || (!in_data.z[ZW-1] && in_data.z > Z_90)) begin
      zc = Z_90[20:0];
    end else if (in_data.z[ZW-1]) begin
      zc = '0;
    end else begin
      zc = in_data.z[20:0];
    end
    unique case ({in_data.neg_u, in_data.neg_v})
      2'b00:   dir_next = DIR_270 - {2'b00, zc};
      2'b10:   dir_next = DIR_90 + {2'b00, zc};
      2'b11:   dir_next = DIR_90 - {2'b00, zc};
      default: dir_next = DIR_270 + {2'b00, zc};
    endcase
  end

  assign dir_rnd = dir1 + DIR_ROUND;
  assign dq      = dir_rnd[22:8];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dir1   <= dir_next;
      speed1 <= in_data.root[15:0] + {15'd0, in_data.rem > in_data.root};
      calm1  <= in_data.u_zero & in_data.v_zero;

      out_data.speed <= speed1;
      if (calm1) begin
        out_data.direction <= DIR_CALM;
      end else if (dq >= DIR_FULL) begin
        out_data.direction <= '0;
      end else begin
        out_data.direction <= dq;
      end
    end
  end

endmodule

// File: design/wvsd_skid.sv
`timescale 1ns / 1ps
// Output register with a skid entry; its ready stalls the whole pipeline.
// Depends on wvsd_pkg.
module wvsd_skid (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  wvsd_pkg::res_t      in_data,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output wvsd_pkg::res_t      out_data
);
  import wvsd_pkg::*;

  logic full;
  res_t skid;

  assign in_ready = ~full;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
      out_valid <= 1'b0;
    end else if (full) begin
      if (out_ready) begin
        full <= 1'b0;
      end
    end else if (!out_valid || out_ready) begin
      out_valid <= in_valid;
    end else if (in_valid) begin
      full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (full) begin
      if (out_ready) begin
        out_data <= skid;
      end
    end else if (!out_valid || out_ready) begin
      out_data <= in_data;
    end else begin
      skid <= in_data;
    end
  end

endmodule

// File: design/wind_vector_to_speed_direction_unit.sv
`timescale 1ns / 1ps
// Channel   Dir  Transfer carries
// s_axis    in   one wind vector: east, north components
// m_axis    out  speed and direction of that vector
// cfg       in   input_in_knots flag, single-cycle write
//
// One vector per cycle sustained while m_axis does not stall. 7 + max(CORDIC_STEPS, 17)
// register stages, the depth set by the CORDIC/square root stage chain.
// rst is synchronous and clears all valid bits and the knots flag.
// A stalled output holds one result plus one in the skid entry; the pipeline
// then freezes and s_axis_tready drops until the skid entry drains.
// Top level; instantiates wvsd_prep, wvsd_core, wvsd_post, wvsd_skid (wvsd_pkg types).
module wind_vector_to_speed_direction_unit #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] east_component, [31:16] north_component
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // [15:0] wind_speed, [30:16] wind_direction, [31] zero
);
  import wvsd_pkg::*;

  logic  input_in_knots;
  logic  pipe_en;
  logic  prep_valid, core_valid, post_valid;
  prep_t prep_data;
  core_t core_data;
  res_t  post_data, out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      input_in_knots <= 1'b0;
    end else if (cfg_we) begin
      input_in_knots <= cfg_wdata;
    end
  end

  assign s_axis_tready = pipe_en;

  wvsd_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .en        (pipe_en),
    .knots     (input_in_knots),
    .in_valid  (s_axis_tvalid),
    .in_u      (s_axis_tdata[15:0]),
    .in_v      (s_axis_tdata[31:16]),
    .out_valid (prep_valid),
    .out_data  (prep_data)
  );

  wvsd_core #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .en        (pipe_en),
    .in_valid  (prep_valid),
    .in_data   (prep_data),
    .out_valid (core_valid),
    .out_data  (core_data)
  );

  wvsd_post u_post (
    .clk       (clk),
    .rst       (rst),
    .en        (pipe_en),
    .in_valid  (core_valid),
    .in_data   (core_data),
    .out_valid (post_valid),
    .out_data  (post_data)
  );

  wvsd_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (post_valid),
    .in_data   (post_data),
    .in_ready  (pipe_en),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_data)
  );

  assign m_axis_tdata = {1'b0, out_data.direction, out_data.speed};

`ifndef SYNTHESIS
  a_dir_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[30:16] < DIR_FULL))
    else $error("direction out of range");

  a_speed_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[15:0] <= 16'd46341))
    else $error("speed out of range");

  a_stall_holds_result: assert property (@(posedge clk) disable iff (rst)
    !pipe_en |-> m_axis_tvalid)
    else $error("pipeline stalled with no result waiting");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    $fell(pipe_en) |-> $past(m_axis_tvalid && !m_axis_tready && post_valid))
    else $error("input stalled without a blocked transfer");
`endif

endmodule

// File: sim/tb_wind_vector_to_speed_direction_unit.sv
`timescale 1ns / 1ps
// Self-checking bench for wind_vector_to_speed_direction_unit: random and directed wind vectors
// in m/s and knots, stream handshakes with random stalls, bit-exact speed/direction prediction.
// Depends only on the RTL of the unit (and its package, pulled in by the RTL itself).

localparam int      CORDIC_ITERS = 16;
localparam longint  DEG_STEPS    = 16384;           // angle unit: 1/16384 degree
localparam longint  QUARTER_TURN = 90 * DEG_STEPS;
localparam longint  HALF_TURN    = 180 * DEG_STEPS;
localparam longint  DIR_OFFSET   = 270 * DEG_STEPS;
localparam longint  FULL_TURN    = 360 * DEG_STEPS;
localparam longint  DIR_WRAP     = 360 * 64;        // 360 degrees in output units
localparam longint  CALM_DIR     = 270 * 64;
localparam longint  KNOT_NUM     = 1852;
localparam longint  KNOT_BIAS    = 1800;
localparam longint  KNOT_DEN     = 3600;
localparam longint  ATAN_STEP [24] = '{
  737280, 435242, 229970, 116736, 58595, 29326, 14667, 7334,
  3667, 1833, 917, 458, 229, 115, 57, 29,
  14, 7, 4, 2, 1, 0, 0, 0
};

typedef struct {
  logic [15:0] east;
  logic [15:0] north;
  bit          knots;
  logic [15:0] speed;
  logic [14:0] direction;
} wind_t;

class wind_scoreboard;
  bit    in_knots;
  wind_t pending_winds[$];
  int    errors;
  int    checked;

  function void set_knots(bit k);
    in_knots = k;
  endfunction

  function int pending();
    return pending_winds.size();
  endfunction

  function wind_t speed_dir_of(logic [15:0] u, logic [15:0] v);
    wind_t  w;
    longint mu, mv, sq, root, cand;
    longint x, y, z, dx, dy, theta, angle, dq;
    bit     nu, nv;
    w.east  = u;
    w.north = v;
    w.knots = in_knots;
    nu = u[15];
    nv = v[15];
    mu = nu ? 65536 - longint'(u) : longint'(u);
    mv = nv ? 65536 - longint'(v) : longint'(v);
    if (in_knots) begin
      mu = (mu * KNOT_NUM + KNOT_BIAS) / KNOT_DEN;
      mv = (mv * KNOT_NUM + KNOT_BIAS) / KNOT_DEN;
    end
    if (mu == 0) nu = 1'b0;
    if (mv == 0) nv = 1'b0;

    // floor root bit by bit, then round to nearest
    sq   = mu * mu + mv * mv;
    root = 0;
    for (int b = 16; b >= 0; b--) begin
      cand = root | (longint'(1) << b);
      if (cand * cand <= sq) root = cand;
    end
    if (sq - root * root > root) root++;
    w.speed = root[15:0];

    if (mu == 0 && mv == 0) begin
      w.direction = CALM_DIR[14:0];
      return w;
    end

    z = 0;
    if (mv == 0) begin
      z = 0;
    end else if (mu == 0) begin
      z = QUARTER_TURN;
    end else begin
      x = mu <<< 24;
      y = mv <<< 24;
      for (int i = 0; i < CORDIC_ITERS && i < 24; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x += dx;
          y -= dy;
          z += ATAN_STEP[i];
        end else begin
          x -= dx;
          y += dy;
          z -= ATAN_STEP[i];
        end
      end
      if (z < 0) z = 0;
      if (z > QUARTER_TURN) z = QUARTER_TURN;
    end

    if (!nu && !nv)     theta = z;
    else if (nu && !nv) theta = HALF_TURN - z;
    else if (nu && nv)  theta = z - HALF_TURN;
    else                theta = -z;

    angle = DIR_OFFSET - theta;
    if (angle >= FULL_TURN) angle -= FULL_TURN;
    if (angle < 0) angle += FULL_TURN;
    dq = (angle + 128) >>> 8;
    if (dq >= DIR_WRAP) dq -= DIR_WRAP;
    w.direction = dq[14:0];
    return w;
  endfunction

  function void note_vector(logic [15:0] u, logic [15:0] v);
    pending_winds.push_back(speed_dir_of(u, v));
  endfunction

  function void report(string msg);
    errors++;
    if (errors <= 10) $display("[%0t] MISMATCH: %s", $time, msg);
  endfunction

  function void check_result(logic [15:0] speed, logic [14:0] direction);
    wind_t w;
    checked++;
    if (pending_winds.size() == 0) begin
      report($sformatf("unexpected result speed=%0d dir=%0d", speed, direction));
      return;
    end
    w = pending_winds.pop_front();
    if (speed !== w.speed || direction !== w.direction)
      report($sformatf("u=%0d v=%0d knots=%0d: expected speed=%0d dir=%0d, got speed=%0d dir=%0d",
                       $signed(w.east), $signed(w.north), w.knots, w.speed, w.direction,
                       speed, direction));
  endfunction
endclass

module tb_wind_vector_to_speed_direction_unit;
  localparam int QUIET_LIMIT   = 2000;  // cycles with no transfer on either side
  localparam int DRAIN_CYCLES  = 40;    // longer than the pipeline latency
  localparam int RANDOM_ITEMS  = 250;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic        cfg_wdata;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;

  int send_idle_pct;
  int recv_idle_pct;
  int vectors_sent;
  int quiet_cycles;

  wind_scoreboard book;

  wind_vector_to_speed_direction_unit #(
    .CORDIC_STEPS(CORDIC_ITERS)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      book.check_result(m_axis_tdata[15:0], m_axis_tdata[30:16]);
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
               QUIET_LIMIT, book.pending());
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_vector(input int u, input int v);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= $urandom;
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {v[15:0], u[15:0]};
    do @(posedge clk); while (!s_axis_tready);
    book.note_vector(u[15:0], v[15:0]);
    vectors_sent++;
  endtask

  // register only changes with the pipeline empty
  task automatic set_knots(input bit k);
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= k;
    @(negedge clk);
    cfg_we    <= 1'b0;
    book.set_knots(k);
  endtask

  // mix of zeros, extremes, small magnitudes and full-range values
  function automatic int pick_component();
    case ($urandom_range(7))
      0: return 0;
      1: begin
        case ($urandom_range(3))
          0: return -32768;
          1: return 32767;
          2: return -1;
          default: return 1;
        endcase
      end
      2: return int'($urandom_range(511)) - 256;
      default: return int'($urandom_range(65535)) - 32768;
    endcase
  endfunction

  task automatic send_random(input int n);
    repeat (n) send_vector(pick_component(), pick_component());
  endtask

  initial begin
    book          = new();
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_wdata     = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    send_idle_pct = 25;
    recv_idle_pct = 50;
    vectors_sent  = 0;
    quiet_cycles  = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    set_knots(1'b0);
    send_vector(0, 0);          // calm
    send_vector(1, 0);
    send_vector(-1, 0);         // on the u axis, wind from the east
    send_vector(0, 1);
    send_vector(0, -1);         // on the v axis, wraps to 0 degrees
    send_vector(32767, 0);
    send_vector(-32768, 0);
    send_vector(0, 32767);
    send_vector(0, -32768);
    send_vector(-32768, -32768);  // largest speed
    send_vector(32767, 32767);
    send_vector(-32768, 32767);
    send_vector(32767, -32768);
    send_vector(256, 256);
    send_vector(-256, 256);
    send_vector(-256, -256);
    send_vector(256, -256);
    send_vector(1, -32768);     // rounds up to 360, wraps to 0
    send_vector(-1, 32767);
    send_vector(3, 4);

    set_knots(1'b1);
    send_vector(0, 0);
    send_vector(1, 1);
    send_vector(-1, 0);
    send_vector(-32768, -32768);
    send_vector(2, -3);
    send_random(RANDOM_ITEMS);

    send_idle_pct = 50;
    recv_idle_pct = 25;
    set_knots(1'b0);
    send_random(RANDOM_ITEMS);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_knots(1'b1);
    send_random(RANDOM_ITEMS / 2);
    set_knots(1'b0);
    send_random(RANDOM_ITEMS / 2);

    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d wind vectors (25 directed, rest random) in m/s and knots,", vectors_sent);
    $display("under three stall patterns; %0d results checked, %0d mismatches",
             book.checked, book.errors);
    if (book.errors == 0 && book.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
